[src/rgbled_pkg.sv]
// Shared widths, codes and types for the RGB LED pattern generator.
package rgbled_pkg;

  localparam int TICK_W      = 32;
  localparam int DUTY_W      = 8;
  localparam int MODE_W      = 3;
  localparam int PHASE_W     = 2;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;
  localparam int PERIOD_W    = 12;

  localparam int WAVE_DEPTH_DEF = 1024;

  localparam int CORE_STAGES = 6;
  localparam int PIPE_STAGES = CORE_STAGES + 1;

  localparam logic [DUTY_W-1:0]   DUTY_MAX      = 8'd255;
  localparam logic [PERIOD_W-1:0] PERIOD_MEDIUM = 12'd900;
  localparam logic [PERIOD_W-1:0] PERIOD_SOFT   = 12'd1400;
  localparam logic [PERIOD_W-1:0] PERIOD_SLOW   = 12'd2200;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF          = 3'd0,
    MODE_RED_PULSE    = 3'd1,
    MODE_YELLOW       = 3'd2,
    MODE_BREATH       = 3'd3,
    MODE_GREEN        = 3'd4,
    MODE_YELLOW_PULSE = 3'd5,
    MODE_BLUE         = 3'd6,
    MODE_ERROR        = 3'd7
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PHASE_IDLE   = 2'd0,
    PHASE_INHALE = 2'd1,
    PHASE_EXHALE = 2'd2,
    PHASE_REST   = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_PHASE = 2'd1,
    CFG_CHAN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PER_MEDIUM = 2'd0,
    PER_SOFT   = 2'd1,
    PER_SLOW   = 2'd2
  } period_sel_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_FULL  = 2'd1,
    SRC_PULSE = 2'd2,
    SRC_RAMP  = 2'd3
  } chan_src_t;

  typedef struct packed {
    chan_src_t          red;
    chan_src_t          green;
    chan_src_t          blue;
    logic [CHAN_W-1:0]  mask;
  } led_ctl_t;

endpackage

[src/rgbled_pulse.sv]
// Raised-cosine pulse path: time modulo period, table index, wave table read.
module rgbled_pulse import rgbled_pkg::*; #(
  parameter int WAVE_TABLE_DEPTH = WAVE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic [CORE_STAGES-1:0] adv,
  input  logic [TICK_W-1:0]      now_ms,
  input  period_sel_t            period_sel,
  output logic [DUTY_W-1:0]      duty
);

  localparam int IDX_W       = $clog2(WAVE_TABLE_DEPTH);
  localparam int RECIP_SHIFT = 41;
  localparam int QUOT_W      = 2 * TICK_W - RECIP_SHIFT;
  localparam int QP_W        = QUOT_W + PERIOD_W;
  localparam int REM_W       = PERIOD_W + 1;
  localparam int IDX_SHIFT   = IDX_W + 24;
  localparam int SCALE_W     = IDX_W + IDX_SHIFT - 9;
  localparam int PROD2_W     = PERIOD_W + SCALE_W;
  localparam int IDXF_W      = PROD2_W - IDX_SHIFT;

  localparam logic [TICK_W-1:0] RECIP_MEDIUM =
    TICK_W'((64'd1 << RECIP_SHIFT) / 64'(PERIOD_MEDIUM));
  localparam logic [TICK_W-1:0] RECIP_SOFT =
    TICK_W'((64'd1 << RECIP_SHIFT) / 64'(PERIOD_SOFT));
  localparam logic [TICK_W-1:0] RECIP_SLOW =
    TICK_W'((64'd1 << RECIP_SHIFT) / 64'(PERIOD_SLOW));

  localparam logic [SCALE_W-1:0] SCALE_MEDIUM = SCALE_W'(64'(WAVE_TABLE_DEPTH) *
    (((64'd1 << IDX_SHIFT) + 64'(PERIOD_MEDIUM) - 64'd1) / 64'(PERIOD_MEDIUM)));
  localparam logic [SCALE_W-1:0] SCALE_SOFT = SCALE_W'(64'(WAVE_TABLE_DEPTH) *
    (((64'd1 << IDX_SHIFT) + 64'(PERIOD_SOFT) - 64'd1) / 64'(PERIOD_SOFT)));
  localparam logic [SCALE_W-1:0] SCALE_SLOW = SCALE_W'(64'(WAVE_TABLE_DEPTH) *
    (((64'd1 << IDX_SHIFT) + 64'(PERIOD_SLOW) - 64'd1) / 64'(PERIOD_SLOW)));

  localparam real PI_VAL     = 3.14159265358979323846;
  localparam real ANGLE_STEP = 2.0 * PI_VAL / WAVE_TABLE_DEPTH;

  function automatic logic [DUTY_W-1:0] wave_value(int idx);
    int  j;
    real v;
    j = (2 * idx <= WAVE_TABLE_DEPTH) ? idx : WAVE_TABLE_DEPTH - idx;
    if (j == 0) begin
      return '0;
    end
    if (2 * j == WAVE_TABLE_DEPTH) begin
      return DUTY_MAX;
    end
    v = 255.0 * (0.5 - 0.5 * $cos(ANGLE_STEP * j));
    if (v >= 255.0) begin
      return DUTY_MAX;
    end
    return DUTY_W'($rtoi(v));
  endfunction

  function automatic logic [PERIOD_W-1:0] period_value(period_sel_t sel);
    case (sel)
      PER_MEDIUM: return PERIOD_MEDIUM;
      PER_SOFT:   return PERIOD_SOFT;
      PER_SLOW:   return PERIOD_SLOW;
      default:    return PERIOD_MEDIUM;
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] recip_value(period_sel_t sel);
    case (sel)
      PER_MEDIUM: return RECIP_MEDIUM;
      PER_SOFT:   return RECIP_SOFT;
      PER_SLOW:   return RECIP_SLOW;
      default:    return RECIP_MEDIUM;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] scale_value(period_sel_t sel);
    case (sel)
      PER_MEDIUM: return SCALE_MEDIUM;
      PER_SOFT:   return SCALE_SOFT;
      PER_SLOW:   return SCALE_SLOW;
      default:    return SCALE_MEDIUM;
    endcase
  endfunction

  logic [DUTY_W-1:0] wave_rom [WAVE_TABLE_DEPTH];

  for (genvar gi = 0; gi < WAVE_TABLE_DEPTH; gi++) begin : g_rom
    assign wave_rom[gi] = wave_value(gi);
  end

  logic [2*TICK_W-1:0] prod1;
  logic [REM_W-1:0]    low1, low2;
  period_sel_t         sel1, sel2, sel3, sel4;
  logic [QP_W-1:0]     qp_full;
  logic [REM_W-1:0]    qp2;
  logic [REM_W-1:0]    rem3;
  logic [PERIOD_W-1:0] rem4;
  logic [PROD2_W-1:0]  prod5;
  logic [IDXF_W-1:0]   idx_full;
  logic [IDX_W-1:0]    idx;

  always_comb begin
    qp_full  = QP_W'(prod1[2*TICK_W-1:RECIP_SHIFT]) * QP_W'(period_value(sel1));
    idx_full = prod5[PROD2_W-1:IDX_SHIFT];
    if (idx_full >= IDXF_W'(WAVE_TABLE_DEPTH)) begin
      idx = IDX_W'(WAVE_TABLE_DEPTH - 1);
    end else begin
      idx = idx_full[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod1 <= (2*TICK_W)'(now_ms) * (2*TICK_W)'(recip_value(period_sel));
      low1  <= now_ms[REM_W-1:0];
      sel1  <= period_sel;
    end
    if (adv[1]) begin
      qp2  <= qp_full[REM_W-1:0];
      low2 <= low1;
      sel2 <= sel1;
    end
    if (adv[2]) begin
      rem3 <= low2 - qp2;
      sel3 <= sel2;
    end
    if (adv[3]) begin
      if (rem3 >= REM_W'(period_value(sel3))) begin
        rem4 <= PERIOD_W'(rem3 - REM_W'(period_value(sel3)));
      end else begin
        rem4 <= rem3[PERIOD_W-1:0];
      end
      sel4 <= sel3;
    end
    if (adv[4]) begin
      prod5 <= PROD2_W'(rem4) * PROD2_W'(scale_value(sel4));
    end
    if (adv[5]) begin
      duty <= wave_rom[idx];
    end
  end

endmodule

[src/rgbled_ramp.sv]
// Guide ramp path: pipelined restoring divider for floor(255 * e / d).
module rgbled_ramp import rgbled_pkg::*; (
  input  logic                   clk,
  input  logic [CORE_STAGES-1:0] adv,
  input  logic [TICK_W-1:0]      phase_elapsed_ms,
  input  logic [TICK_W-1:0]      phase_duration_ms,
  input  logic                   inhale,
  output logic [DUTY_W-1:0]      duty
);

  localparam int NUM_W          = TICK_W + DUTY_W;
  localparam int DIV_STAGES     = CORE_STAGES - 2;
  localparam int BITS_PER_STAGE = DUTY_W / DIV_STAGES;

  logic [TICK_W-1:0] num_src;
  logic [TICK_W-1:0] dur1;
  logic              sat1;
  logic [DUTY_W-1:0] fix1;

  logic [NUM_W-1:0]  rem [DIV_STAGES];
  logic [TICK_W-1:0] dur [DIV_STAGES];
  logic [DUTY_W-1:0] quo [DIV_STAGES+1];
  logic              sat [DIV_STAGES+1];
  logic [DUTY_W-1:0] fix [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_src <= inhale ? phase_elapsed_ms : phase_duration_ms - phase_elapsed_ms;
      dur1    <= phase_duration_ms;
      sat1    <= (phase_duration_ms == '0) || (phase_elapsed_ms >= phase_duration_ms);
      fix1    <= ((phase_duration_ms == '0) != inhale) ? DUTY_MAX : '0;
    end
    if (adv[1]) begin
      rem[0] <= {num_src, {DUTY_W{1'b0}}} - NUM_W'(num_src);
      dur[0] <= dur1;
      quo[0] <= '0;
      sat[0] <= sat1;
      fix[0] <= fix1;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [NUM_W-1:0]  r_step [BITS_PER_STAGE+1];
    logic [DUTY_W-1:0] q_step [BITS_PER_STAGE+1];

    always_comb begin
      logic [NUM_W:0] trial;
      int             bitpos;
      r_step[0] = rem[s];
      q_step[0] = quo[s];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        bitpos = DUTY_W - 1 - s * BITS_PER_STAGE - b;
        trial  = {1'b0, r_step[b]} - {1'b0, (NUM_W'(dur[s]) << bitpos)};
        q_step[b+1] = {q_step[b][DUTY_W-2:0], ~trial[NUM_W]};
        r_step[b+1] = trial[NUM_W] ? r_step[b] : trial[NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[2+s]) begin
        quo[s+1] <= q_step[BITS_PER_STAGE];
        sat[s+1] <= sat[s];
        fix[s+1] <= fix[s];
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[2+s]) begin
          rem[s+1] <= r_step[BITS_PER_STAGE];
          dur[s+1] <= dur[s];
        end
      end
    end
  end

  assign duty = sat[DIV_STAGES] ? fix[DIV_STAGES] : quo[DIV_STAGES];

endmodule

[src/rgb_led_pattern_generator_core.sv]
// Top level of the RGB LED pattern generator: registers, pipeline control, color select.
// One tick transaction gives one duty result. The block takes a tick every cycle while
// the output is not stalled, and each result passes six stages in which the pulse path
// reduces the time modulo the period by reciprocal multiplication, scales the remainder to
// a wave table index and reads the wave table into a register, while the ramp path runs a
// restoring divider at two quotient bits per stage, then one output register. Each stage
// holds its item while the stage after it is full and stalled, so bubbles are squeezed out
// and a new tick is taken while a finished result still waits at the output. The wave
// table is constant and needs no clearing after reset. Configuration writes take effect
// at once and are meant for times when no tick is in flight.
module rgb_led_pattern_generator_core import rgbled_pkg::*; #(
  parameter int WAVE_TABLE_DEPTH = WAVE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_W-1:0]     now_ms,
  input  logic [TICK_W-1:0]     phase_elapsed_ms,
  input  logic [TICK_W-1:0]     phase_duration_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     red_duty,
  output logic [DUTY_W-1:0]     green_duty,
  output logic [DUTY_W-1:0]     blue_duty,
  output logic [CHAN_W-1:0]     write_mask
);

  mode_t             mode;
  phase_t            phase;
  logic [CHAN_W-1:0] chan_en;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] rdy;

  led_ctl_t    ctl_in;
  period_sel_t sel_in;
  led_ctl_t    ctl [CORE_STAGES];

  logic [DUTY_W-1:0] pulse_duty;
  logic [DUTY_W-1:0] ramp_duty;

  function automatic logic [DUTY_W-1:0] pick(chan_src_t src, logic [DUTY_W-1:0] pv,
                                             logic [DUTY_W-1:0] rv);
    case (src)
      SRC_FULL:  return DUTY_MAX;
      SRC_PULSE: return pv;
      SRC_RAMP:  return rv;
      default:   return '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_OFF;
      phase   <= PHASE_IDLE;
      chan_en <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode    <= mode_t'(cfg_data[MODE_W-1:0]);
        CFG_PHASE: phase   <= phase_t'(cfg_data[PHASE_W-1:0]);
        CFG_CHAN:  chan_en <= cfg_data[CHAN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    ctl_in = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO, mask: chan_en};
    sel_in = PER_MEDIUM;
    case (mode)
      MODE_RED_PULSE, MODE_ERROR: ctl_in.red = SRC_PULSE;
      MODE_YELLOW: begin
        ctl_in.red   = SRC_FULL;
        ctl_in.green = SRC_FULL;
      end
      MODE_BREATH: begin
        if (phase inside {PHASE_INHALE, PHASE_EXHALE}) begin
          ctl_in.red  = SRC_RAMP;
          ctl_in.blue = SRC_RAMP;
        end else begin
          ctl_in.red   = SRC_PULSE;
          ctl_in.green = SRC_PULSE;
          sel_in       = (phase == PHASE_REST) ? PER_SLOW : PER_SOFT;
        end
      end
      MODE_GREEN: ctl_in.green = SRC_FULL;
      MODE_YELLOW_PULSE: begin
        ctl_in.red   = SRC_PULSE;
        ctl_in.green = SRC_PULSE;
      end
      MODE_BLUE: ctl_in.blue = SRC_FULL;
      default: ;
    endcase
  end

  // advance a stage when it is empty or the next stage advances
  always_comb begin
    rdy[PIPE_STAGES-1] = ~vld[PIPE_STAGES-1] | out_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctl[0] <= ctl_in;
    end
    for (int k = 1; k < CORE_STAGES; k++) begin
      if (rdy[k]) begin
        ctl[k] <= ctl[k-1];
      end
    end
    if (rdy[PIPE_STAGES-1]) begin
      red_duty   <= pick(ctl[CORE_STAGES-1].red, pulse_duty, ramp_duty);
      green_duty <= pick(ctl[CORE_STAGES-1].green, pulse_duty, ramp_duty);
      blue_duty  <= pick(ctl[CORE_STAGES-1].blue, pulse_duty, ramp_duty);
      write_mask <= ctl[CORE_STAGES-1].mask;
    end
  end

  rgbled_pulse #(
    .WAVE_TABLE_DEPTH(WAVE_TABLE_DEPTH)
  ) u_pulse (
    .clk        (clk),
    .adv        (rdy[CORE_STAGES-1:0]),
    .now_ms     (now_ms),
    .period_sel (sel_in),
    .duty       (pulse_duty)
  );

  rgbled_ramp u_ramp (
    .clk               (clk),
    .adv               (rdy[CORE_STAGES-1:0]),
    .phase_elapsed_ms  (phase_elapsed_ms),
    .phase_duration_ms (phase_duration_ms),
    .inhale            (phase == PHASE_INHALE),
    .duty              (ramp_duty)
  );

endmodule
